FILE: hdl/keyframe_interpolator_top_macros.svh
// Assertion macros for the keyframe interpolator.
// Taken in by the RTL files that carry concurrent checks; no other dependencies.
`ifndef KEYFRAME_INTERPOLATOR_TOP_MACROS_SVH
`define KEYFRAME_INTERPOLATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// plain property, sampled on the clock, off during reset
`define KFI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("keyframe interpolator check failed");
// same-cycle implication
`define KFI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyframe interpolator check failed");
// next-cycle implication
`define KFI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyframe interpolator check failed");
`else
`define KFI_ASSERT(label, clk, rst, prop)
`define KFI_ASSERT_IMP(label, clk, rst, ante, cons)
`define KFI_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/kfi_pkg.sv
// Shared constants, codes and types of the keyframe interpolator.
// No dependencies; used by every module of the block except kfi_ram.
package kfi_pkg;

   localparam int MAX_KEYS_DEF   = 64;
   localparam int FRAME_BITS_DEF = 16;

   localparam int VALUE_W     = 32;
   localparam int MODE_W      = 2;
   localparam int RATIO_W     = 16;
   localparam int KEY_INDEX_W = 6;
   localparam int KEY_COUNT_W = 7;
   localparam int IN_FRAME_W  = 16;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   localparam logic [MODE_W-1:0] MODE_CONSTANT = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_BLEND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

FILE: hdl/kfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/kfi_ratio_div.sv
// Bit-serial restoring divider: ratio = floor(d * 2^16 / span), with d < span.
// Depends on kfi_pkg.
module kfi_ratio_div #(
   parameter int FRAME_BITS = kfi_pkg::FRAME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [FRAME_BITS-1:0]        d,
   input  logic [FRAME_BITS-1:0]        span,
   output logic [kfi_pkg::RATIO_W-1:0]  ratio,
   output kfi_pkg::unit_status_type     status
);

   localparam int CNT_W = $clog2(kfi_pkg::RATIO_W);

   logic [FRAME_BITS-1:0]       rem_ff, rem_in;
   logic [FRAME_BITS-1:0]       span_ff, span_in;
   logic [kfi_pkg::RATIO_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [FRAME_BITS:0]         shifted;
   logic                        take;

   // remainder stays below span, so twice it fits one extra bit
   assign shifted = {rem_ff, 1'b0};
   assign take    = shifted >= {1'b0, span_ff};

   always_comb begin
      rem_in  = rem_ff;
      span_in = span_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = d;
         span_in = span;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? FRAME_BITS'(shifted - {1'b0, span_ff}) : shifted[FRAME_BITS-1:0];
         q_in   = {q_ff[kfi_pkg::RATIO_W-2:0], take};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(kfi_pkg::RATIO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      span_ff <= span_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

   assign ratio       = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: hdl/kfi_blend.sv
// Two-stage blend: diff * ratio, then round to nearest, add past value, saturate.
// Depends on kfi_pkg.
module kfi_blend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [kfi_pkg::VALUE_W:0]    diff,
   input  logic signed [kfi_pkg::VALUE_W-1:0]  past_value,
   input  logic [kfi_pkg::RATIO_W-1:0]         ratio,
   output logic signed [kfi_pkg::VALUE_W-1:0]  value,
   output kfi_pkg::unit_status_type            status
);

   localparam int PROD_W = kfi_pkg::VALUE_W + kfi_pkg::RATIO_W + 2;
   localparam int SUM_W  = kfi_pkg::VALUE_W + 3;
   localparam int VW     = kfi_pkg::VALUE_W;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (kfi_pkg::RATIO_W - 1);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VW-1:0]     past_s1_ff;
   logic                     v1_ff;
   logic signed [VW-1:0]     value_ff, value_in;
   logic                     v2_ff;
   logic signed [PROD_W-1:0] rounded;
   logic signed [PROD_W-1:0] shifted;
   logic signed [SUM_W-1:0]  step;
   logic signed [SUM_W-1:0]  sum;

   assign prod_in = diff * $signed({1'b0, ratio});

   // arithmetic shift of the rounded product is the floor division
   assign rounded = prod_ff + ROUND_HALF;
   assign shifted = rounded >>> kfi_pkg::RATIO_W;
   assign step    = shifted[SUM_W-1:0];
   assign sum     = SUM_W'(past_s1_ff) + step;

   always_comb begin
      if (sum[SUM_W-1] && !(&sum[SUM_W-2:VW-1])) begin
         value_in = {1'b1, {(VW-1){1'b0}}};
      end else if (!sum[SUM_W-1] && (|sum[SUM_W-2:VW-1])) begin
         value_in = {1'b0, {(VW-1){1'b1}}};
      end else begin
         value_in = sum[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      prod_ff    <= prod_in;
      past_s1_ff <= past_value;
      value_ff   <= value_in;
   end

   assign value       = value_ff;
   assign status.busy = v1_ff | v2_ff;
   assign status.done = v2_ff;

endmodule

FILE: hdl/keyframe_interpolator_top.sv
// Keyframe interpolator: keyframe table in one RAM, scan sequencer, divider, blend.
// Depends on kfi_pkg, kfi_ram, kfi_ratio_div, kfi_blend and the assertion macros.
// Keyframe write: the table write happens as the item is taken; the next item can be taken the cycle after.
// Query: one RAM read per valid key while scanning, then the serial divider and the blend;
//   req_ready stays low until the result is loaded for output.
// Synchronous active-high reset clears key_count and control; table contents persist.
`include "keyframe_interpolator_top_macros.svh"

module keyframe_interpolator_top #(
   parameter int MAX_KEYS   = kfi_pkg::MAX_KEYS_DEF,
   parameter int FRAME_BITS = kfi_pkg::FRAME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [kfi_pkg::KEY_COUNT_W-1:0]       csr_key_count,
   // request items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_type,
   input  logic [kfi_pkg::KEY_INDEX_W-1:0]       req_key_index,
   input  logic [kfi_pkg::IN_FRAME_W-1:0]        req_key_frame,
   input  logic signed [kfi_pkg::VALUE_W-1:0]    req_key_value,
   input  logic [kfi_pkg::MODE_W-1:0]            req_key_mode,
   input  logic [kfi_pkg::IN_FRAME_W-1:0]        req_current_frame,
   // response items
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [kfi_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic                                  rsp_out_status,
   output logic [kfi_pkg::KEY_INDEX_W-1:0]       rsp_segment_index
);

   localparam int IDX_W   = $clog2(MAX_KEYS);
   localparam int CNT_W   = $clog2(MAX_KEYS + 1);
   localparam int VW      = kfi_pkg::VALUE_W;
   localparam int MW      = kfi_pkg::MODE_W;
   localparam int ENTRY_W = FRAME_BITS + VW + MW;

   // entry layout: {mode, value, frame}
   function automatic logic [FRAME_BITS-1:0] e_frame(input logic [ENTRY_W-1:0] e);
      return e[FRAME_BITS-1:0];
   endfunction
   function automatic logic signed [VW-1:0] e_value(input logic [ENTRY_W-1:0] e);
      return e[FRAME_BITS+VW-1:FRAME_BITS];
   endfunction
   function automatic logic [MW-1:0] e_mode(input logic [ENTRY_W-1:0] e);
      return e[ENTRY_W-1:ENTRY_W-MW];
   endfunction

   kfi_pkg::state_type state_ff, state_in;

   logic [kfi_pkg::KEY_COUNT_W-1:0] key_count_ff;
   logic [FRAME_BITS-1:0]           cur_ff, cur_in;
   logic [CNT_W-1:0]                n_ff, n_in;
   logic [CNT_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]                dat_idx_ff, dat_idx_in;
   logic                            dat_vld_ff, dat_vld_in;
   logic                            prev_hit_ff, prev_hit_in;
   logic                            found_ff, found_in;
   logic [ENTRY_W-1:0]              past_ff, past_in;
   logic [ENTRY_W-1:0]              next_ff, next_in;
   logic [IDX_W-1:0]                past_idx_ff, past_idx_in;
   logic signed [VW:0]              diff_ff, diff_in;
   logic signed [VW-1:0]            res_value_ff, res_value_in;
   logic                            res_status_ff, res_status_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]            rsp_value_ff;
   logic                            rsp_status_ff;
   logic [kfi_pkg::KEY_INDEX_W-1:0] rsp_seg_ff;

   logic                    wr_en;
   logic                    rd_en;
   logic [ENTRY_W-1:0]      wr_data;
   logic [ENTRY_W-1:0]      rd_data;
   logic                    slot_ok;
   logic [CNT_W-1:0]        n_req;
   logic                    hit;
   logic                    has_next;
   logic                    blend_ok;
   logic                    div_start;
   logic                    blend_start;
   logic                    out_load;
   logic [kfi_pkg::RATIO_W-1:0] ratio;
   logic signed [VW-1:0]    blend_value;
   kfi_pkg::unit_status_type div_st;
   kfi_pkg::unit_status_type blend_st;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == kfi_pkg::ST_IDLE);

   assign slot_ok = 32'(req_key_index) < 32'(MAX_KEYS);
   assign n_req   = (32'(key_count_ff) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                        : CNT_W'(key_count_ff);
   assign wr_data = {req_key_mode, req_key_value, FRAME_BITS'(req_key_frame)};

   kfi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_key_index)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   kfi_ratio_div #(
      .FRAME_BITS (FRAME_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .d      (cur_ff - e_frame(past_ff)),
      .span   (e_frame(next_ff) - e_frame(past_ff)),
      .ratio  (ratio),
      .status (div_st)
   );

   kfi_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .start      (blend_start),
      .diff       (diff_ff),
      .past_value (e_value(past_ff)),
      .ratio      (ratio),
      .value      (blend_value),
      .status     (blend_st)
   );

   assign hit      = cur_ff >= e_frame(rd_data);
   assign has_next = (CNT_W'(past_idx_ff) + CNT_W'(1)) < n_ff;
   // blend only inside a rising segment of a non-constant key; everything else returns the past value
   assign blend_ok = found_ff && has_next && (e_mode(past_ff) != kfi_pkg::MODE_CONSTANT)
                     && (e_frame(next_ff) > e_frame(past_ff)) && (cur_ff < e_frame(next_ff));

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      rd_idx_in     = rd_idx_ff;
      dat_idx_in    = dat_idx_ff;
      dat_vld_in    = dat_vld_ff;
      prev_hit_in   = prev_hit_ff;
      found_in      = found_ff;
      past_in       = past_ff;
      next_in       = next_ff;
      past_idx_in   = past_idx_ff;
      diff_in       = diff_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      div_start     = 1'b0;
      blend_start   = 1'b0;
      out_load      = 1'b0;
      case (state_ff)
         kfi_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == kfi_pkg::REQ_WRITE) begin
                  wr_en = slot_ok;
               end else begin
                  cur_in      = FRAME_BITS'(req_current_frame);
                  n_in        = n_req;
                  rd_idx_in   = '0;
                  dat_vld_in  = 1'b0;
                  prev_hit_in = 1'b0;
                  found_in    = 1'b0;
                  past_idx_in = '0;
                  if (n_req == '0) begin
                     res_value_in  = '0;
                     res_status_in = kfi_pkg::STATUS_EMPTY;
                     state_in      = kfi_pkg::ST_OUT;
                  end else begin
                     res_status_in = kfi_pkg::STATUS_OK;
                     state_in      = kfi_pkg::ST_SCAN;
                  end
               end
            end
         end
         kfi_pkg::ST_SCAN: begin
            if (rd_idx_ff < n_ff) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
               dat_idx_in = rd_idx_ff;
               dat_vld_in = 1'b1;
            end else begin
               dat_vld_in = 1'b0;
            end
            if (dat_vld_ff) begin
               // slot 0 is the fallback past key even when it lies ahead
               if (dat_idx_ff == '0) begin
                  past_in     = rd_data;
                  past_idx_in = '0;
                  found_in    = hit;
               end else if (hit) begin
                  past_in     = rd_data;
                  past_idx_in = dat_idx_ff[IDX_W-1:0];
                  found_in    = 1'b1;
               end
               if (prev_hit_ff) begin
                  next_in = rd_data;
               end
               prev_hit_in = hit;
            end else if (rd_idx_ff == n_ff) begin
               if (blend_ok) begin
                  div_start = 1'b1;
                  diff_in   = (VW+1)'(e_value(next_ff)) - (VW+1)'(e_value(past_ff));
                  state_in  = kfi_pkg::ST_DIV;
               end else begin
                  res_value_in = e_value(past_ff);
                  state_in     = kfi_pkg::ST_OUT;
               end
            end
         end
         kfi_pkg::ST_DIV: begin
            if (div_st.done) begin
               blend_start = 1'b1;
               state_in    = kfi_pkg::ST_BLEND;
            end
         end
         kfi_pkg::ST_BLEND: begin
            if (blend_st.done) begin
               res_value_in = blend_value;
               state_in     = kfi_pkg::ST_OUT;
            end
         end
         kfi_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = kfi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kfi_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kfi_pkg::ST_IDLE;
         key_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         dat_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dat_vld_ff   <= dat_vld_in;
         if (csr_valid && csr_ready) begin
            key_count_ff <= csr_key_count;
         end
      end
      cur_ff        <= cur_in;
      n_ff          <= n_in;
      rd_idx_ff     <= rd_idx_in;
      dat_idx_ff    <= dat_idx_in;
      prev_hit_ff   <= prev_hit_in;
      found_ff      <= found_in;
      past_ff       <= past_in;
      next_ff       <= next_in;
      past_idx_ff   <= past_idx_in;
      diff_ff       <= diff_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
         rsp_seg_ff    <= kfi_pkg::KEY_INDEX_W'(past_idx_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_out_status    = rsp_status_ff;
   assign rsp_segment_index = rsp_seg_ff;

   `KFI_ASSERT_IMP(a_idle_units_quiet, clock, reset, state_ff == kfi_pkg::ST_IDLE, !div_st.busy && !blend_st.busy)
   `KFI_ASSERT_NXT(a_query_leaves_idle, clock, reset, req_valid && req_ready && req_type == kfi_pkg::REQ_QUERY, !req_ready)
   `KFI_ASSERT_IMP(a_out_load_free, clock, reset, out_load, !rsp_valid_ff || rsp_ready)
   `KFI_ASSERT_IMP(a_empty_is_zero, clock, reset, rsp_valid_ff && rsp_status_ff == kfi_pkg::STATUS_EMPTY, rsp_value_ff == '0 && rsp_seg_ff == '0)
   `KFI_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == kfi_pkg::ST_SCAN, rd_idx_ff <= n_ff)

endmodule

FILE: tb/sv/tb_keyframe_interpolator_top.sv
// Self-checking bench for keyframe_interpolator_top: directed keyframe and query items,
// then randomised table loads and queries at several key_count settings.
// Depends on kfi_pkg and the keyframe_interpolator_top RTL only.
module tb_keyframe_interpolator_top;

   localparam int KEY_SLOTS   = kfi_pkg::MAX_KEYS_DEF;
   localparam int ITEM_GOAL   = 1700;
   localparam int SETTLE      = 96;
   localparam int STUCK_LIMIT = 2000;
   localparam int PRINT_CAP   = 40;

   localparam int VALUE_W     = kfi_pkg::VALUE_W;
   localparam int MODE_W      = kfi_pkg::MODE_W;
   localparam int RATIO_W     = kfi_pkg::RATIO_W;
   localparam int KEY_INDEX_W = kfi_pkg::KEY_INDEX_W;
   localparam int KEY_COUNT_W = kfi_pkg::KEY_COUNT_W;
   localparam int IN_FRAME_W  = kfi_pkg::IN_FRAME_W;

   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BEZIER = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

   typedef struct {
      logic                      kind;
      logic [KEY_INDEX_W-1:0]    slot;
      logic [IN_FRAME_W-1:0]     frame;
      logic signed [VALUE_W-1:0] value;
      logic [MODE_W-1:0]         mode;
      logic [IN_FRAME_W-1:0]     at_frame;
   } key_req_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      status;
      logic [KEY_INDEX_W-1:0]    seg_idx;
   } interp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [KEY_COUNT_W-1:0]    csr_key_count = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_type = kfi_pkg::REQ_WRITE;
   logic [KEY_INDEX_W-1:0]    req_key_index = '0;
   logic [IN_FRAME_W-1:0]     req_key_frame = '0;
   logic signed [VALUE_W-1:0] req_key_value = '0;
   logic [MODE_W-1:0]         req_key_mode = '0;
   logic [IN_FRAME_W-1:0]     req_current_frame = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic                      rsp_out_status;
   logic [KEY_INDEX_W-1:0]    rsp_segment_index;

   keyframe_interpolator_top uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_key_count     (csr_key_count),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_key_index     (req_key_index),
      .req_key_frame     (req_key_frame),
      .req_key_value     (req_key_value),
      .req_key_mode      (req_key_mode),
      .req_current_frame (req_current_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_status    (rsp_out_status),
      .rsp_segment_index (rsp_segment_index)
   );

   always #6 clock = ~clock;

   // predictor state, updated as items are accepted
   logic [IN_FRAME_W-1:0]     key_frame_tab [KEY_SLOTS];
   logic signed [VALUE_W-1:0] key_value_tab [KEY_SLOTS];
   logic [MODE_W-1:0]         key_mode_tab  [KEY_SLOTS];
   logic [KEY_COUNT_W-1:0]    live_key_count = '0;

   // stimulus-side view of the table, updated as items are queued
   logic [IN_FRAME_W-1:0]     gen_frame   [KEY_SLOTS];
   bit                        gen_written [KEY_SLOTS];

   key_req_type       req_backlog[$];
   interp_result_type pending_results[$];
   key_req_type       cur_req;

   int  items_queued = 0;
   int  items_taken = 0;
   int  queries_taken = 0;
   int  results_seen = 0;
   int  csr_writes = 0;
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  hold_off = 0;
   int  stall_left = 0;
   bit  steady = 1'b0;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP)
         $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic void store_keyframe(key_req_type item);
      key_frame_tab[item.slot] = item.frame;
      key_value_tab[item.slot] = item.value;
      key_mode_tab[item.slot]  = item.mode;
   endfunction

   function automatic interp_result_type interpolate_at(logic [IN_FRAME_W-1:0] at);
      interp_result_type r;
      int     n, past, i;
      bit     found;
      longint pv, nv, d, span, ratio, delta, blended;
      r.value   = '0;
      r.status  = kfi_pkg::STATUS_EMPTY;
      r.seg_idx = '0;
      n = (live_key_count > KEY_SLOTS) ? KEY_SLOTS : live_key_count;
      if (n == 0)
         return r;
      past  = 0;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
         if (at >= key_frame_tab[i]) begin
            past  = i;
            found = 1'b1;
         end
      end
      pv      = key_value_tab[past];
      blended = pv;
      if (found && past + 1 < n && key_mode_tab[past] != kfi_pkg::MODE_CONSTANT) begin
         span = longint'(key_frame_tab[past + 1]) - longint'(key_frame_tab[past]);
         d    = longint'(at) - longint'(key_frame_tab[past]);
         if (span > 0 && d < span) begin
            ratio = (d << RATIO_W) / span;
            nv    = key_value_tab[past + 1];
            // round to nearest, ties upward: arithmetic shift floors
            delta = ((nv - pv) * ratio + 32768) >>> RATIO_W;
            blended = pv + delta;
            if (blended > 64'sh7FFF_FFFF)
               blended = 64'sh7FFF_FFFF;
            if (blended < -64'sh8000_0000)
               blended = -64'sh8000_0000;
         end
      end
      r.value   = blended[VALUE_W-1:0];
      r.status  = kfi_pkg::STATUS_OK;
      r.seg_idx = past[KEY_INDEX_W-1:0];
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin : req_driver
      bit took;
      if (reset) begin
         req_valid <= 1'b0;
         hold_off = 0;
      end else begin
         took = req_valid && req_ready;
         if (took) begin
            items_taken++;
            if (cur_req.kind == kfi_pkg::REQ_QUERY) begin
               pending_results.push_back(interpolate_at(cur_req.at_frame));
               queries_taken++;
            end else begin
               store_keyframe(cur_req);
            end
            hold_off = pick_pause();
         end
         if (!req_valid || took) begin
            if (hold_off > 0) begin
               hold_off--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               cur_req = req_backlog.pop_front();
               req_type          <= cur_req.kind;
               req_key_index     <= cur_req.slot;
               req_key_frame     <= cur_req.frame;
               req_key_value     <= cur_req.value;
               req_key_mode      <= cur_req.mode;
               req_current_frame <= cur_req.at_frame;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result checker with random back-pressure
   always @(posedge clock) begin : rsp_checker
      interp_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result item with none expected (value %0d)",
                                         rsp_out_value));
            end else begin
               want = pending_results.pop_front();
               if (rsp_out_value !== want.value)
                  report_mismatch($sformatf("out_value %0d, expected %0d",
                                            rsp_out_value, want.value));
               if (rsp_out_status !== want.status)
                  report_mismatch($sformatf("out_status %0b, expected %0b",
                                            rsp_out_status, want.status));
               if (rsp_segment_index !== want.seg_idx)
                  report_mismatch($sformatf("segment_index %0d, expected %0d",
                                            rsp_segment_index, want.seg_idx));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
               stall_left = pick_pause();
         end
      end
   end

   // watchdog: no handshake on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STUCK_LIMIT) begin
         $display("tb_keyframe_interpolator_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void push_write(int slot, int frame, logic signed [VALUE_W-1:0] value,
                                      logic [MODE_W-1:0] mode);
      key_req_type item;
      item.kind     = kfi_pkg::REQ_WRITE;
      item.slot     = slot[KEY_INDEX_W-1:0];
      item.frame    = frame[IN_FRAME_W-1:0];
      item.value    = value;
      item.mode     = mode;
      item.at_frame = $urandom_range(0, 16'hFFFF);
      gen_frame[item.slot]   = item.frame;
      gen_written[item.slot] = 1'b1;
      req_backlog.push_back(item);
      items_queued++;
   endfunction

   function automatic void push_query(int at);
      key_req_type item;
      item.kind     = kfi_pkg::REQ_QUERY;
      item.slot     = $urandom_range(0, KEY_SLOTS - 1);
      item.frame    = $urandom_range(0, 16'hFFFF);
      item.value    = $urandom();
      item.mode     = $urandom_range(0, 3);
      item.at_frame = at[IN_FRAME_W-1:0];
      req_backlog.push_back(item);
      items_queued++;
   endfunction

   function automatic int pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 32'sh8000_0000;
      if (r == 1)
         return 32'sh7FFF_FFFF;
      if (r < 5)
         return int'($urandom_range(0, 2097152)) - 1048576;
      return $urandom();
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return kfi_pkg::MODE_CONSTANT;
      if (r == 1)
         return MODE_SPARE;
      return (r < 6) ? MODE_LINEAR : MODE_BEZIER;
   endfunction

   // mostly near a keyframe so blends dominate, with edges and random frames mixed in
   function automatic int pick_query_frame(int n);
      int r, f;
      r = $urandom_range(0, 9);
      if (n == 0 || r < 2)
         return $urandom_range(0, 16'hFFFF);
      if (r == 2)
         return 0;
      if (r == 3)
         return 16'hFFFF;
      f = int'(gen_frame[$urandom_range(0, n - 1)]) + int'($urandom_range(0, 48)) - 3;
      if (f < 0)
         f = 0;
      if (f > 16'hFFFF)
         f = 16'hFFFF;
      return f;
   endfunction

   function automatic int first_unwritten();
      int i;
      for (i = 0; i < KEY_SLOTS; i++)
         if (!gen_written[i])
            return i;
      return KEY_SLOTS;
   endfunction

   task automatic wait_drained();
      while (items_taken != items_queued || pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_key_count(input int cnt);
      @(posedge clock);
      csr_valid     <= 1'b1;
      csr_key_count <= cnt[KEY_COUNT_W-1:0];
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid      <= 1'b0;
      live_key_count = cnt[KEY_COUNT_W-1:0];
      csr_writes++;
   endtask

   initial begin : sequencer
      int round, k, cnt, n, nq, f, i, r;
      bit shuffled;
      for (i = 0; i < KEY_SLOTS; i++)
         gen_written[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, then a small table with edge values and every mode
      write_key_count(0);
      push_query(0);
      push_query(16'hFFFF);
      push_write(0, 10, 32'sh8000_0000, MODE_LINEAR);
      push_write(1, 20, 32'sh7FFF_FFFF, MODE_BEZIER);
      push_write(2, 20, 32'sh0005_0000, MODE_SPARE);
      push_write(3, 16'hFFFF, -32'sd1, kfi_pkg::MODE_CONSTANT);
      push_write(63, 0, 32'sd0, MODE_LINEAR);
      wait_drained();
      write_key_count(4);
      push_query(0);       // ahead of the first key
      push_query(10);
      push_query(15);
      push_query(19);
      push_query(20);      // duplicate frames: later slot wins
      push_query(21);
      push_query(40000);
      push_query(16'hFFFE);
      push_query(16'hFFFF);
      push_write(2, 20, 32'sh0005_0000, kfi_pkg::MODE_CONSTANT);
      push_query(21);      // constant hold
      push_write(1, 5, 32'sh7FFF_FFFF, MODE_BEZIER);
      push_query(7);       // unsorted table
      push_query(3);
      push_query(12);
      wait_drained();

      round = 0;
      while (items_queued < ITEM_GOAL) begin
         round++;
         steady = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 9);
         if (round <= 2 || r == 0)
            k = KEY_SLOTS;
         else if (r == 1)
            k = 1;
         else if (r == 2)
            k = 2;
         else
            k = $urandom_range(3, 16);

         shuffled = ($urandom_range(0, 5) == 0);
         f = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2000);
         for (i = 0; i < k; i++) begin
            if (shuffled) begin
               f = $urandom_range(0, 16'hFFFF);
            end else if (i > 0) begin
               r = $urandom_range(0, 9);
               if (r == 1)
                  f += $urandom_range(1000, 20000);
               else if (r != 0)
                  f += $urandom_range(1, 300);
               if (f > 16'hFFFF)
                  f = 16'hFFFF;
            end
            push_write(i, f, pick_value(), pick_mode());
         end
         wait_drained();

         r = $urandom_range(0, 9);
         if (round == 1)
            cnt = 127;
         else if (round == 2)
            cnt = KEY_SLOTS;
         else if (r == 0)
            cnt = 0;
         else if (r == 1)
            cnt = $urandom_range(0, first_unwritten());
         else if (r == 2 && first_unwritten() == KEY_SLOTS)
            cnt = $urandom_range(KEY_SLOTS + 1, 127);
         else
            cnt = k;
         write_key_count(cnt);
         n = (cnt > KEY_SLOTS) ? KEY_SLOTS : cnt;

         nq = $urandom_range(8, 30);
         for (i = 0; i < nq; i++) begin
            // occasional stray write; inside the live range it unsorts the table
            if ($urandom_range(0, 6) == 0)
               push_write($urandom_range(0, KEY_SLOTS - 1), $urandom_range(0, 16'hFFFF),
                          pick_value(), pick_mode());
            else
               push_query(pick_query_frame(n));
         end
         wait_drained();
      end

      $display("%0d request items (%0d queries), %0d results checked, %0d mismatches",
               items_taken, queries_taken, results_seen, mismatch_count);
      $display("%0d key_count writes over %0d randomised table loads", csr_writes, round);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb_keyframe_interpolator_top passed");
      end else begin
         $display("tb_keyframe_interpolator_top failed");
      end
      $finish;
   end

endmodule
